### rtl/sorted_priority_queue_top_macros.svh
// assertion macros for the sorted priority queue checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// checked only while out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SPQ_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // width of the occupancy result field
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

endpackage

### rtl/spq_cell.sv
// one storage cell of the sorted chain: holds a value and its priority
// depends on spq_pkg
module spq_cell #(
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                      clk_i,
  input  spq_pkg::spq_ctrl_t        ctrl_i,
  input  logic                      occupied_i,
  input  logic [VALUE_WIDTH-1:0]    new_value_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic [VALUE_WIDTH-1:0]    prev_value_i,
  input  logic [PRIORITY_WIDTH-1:0] prev_prio_i,
  input  logic                      prev_le_i,
  input  logic [VALUE_WIDTH-1:0]    next_value_i,
  input  logic [PRIORITY_WIDTH-1:0] next_prio_i,
  output logic [VALUE_WIDTH-1:0]    value_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o,
  output logic                      le_o
);
  import spq_pkg::*;

  logic [VALUE_WIDTH-1:0]    value_q, value_d;
  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic                      greater;

  assign greater = $signed(prio_q) > $signed(new_prio_i);
  // new entry goes behind every held entry with equal or smaller priority
  assign le_o    = occupied_i && !greater;

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.ins && !le_o) begin
      if (prev_le_i) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end else begin
        value_d = prev_value_i;
        prio_d  = prev_prio_i;
      end
    end else if (ctrl_i.rem) begin
      value_d = next_value_i;
      prio_d  = next_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

### rtl/sorted_priority_queue_top.sv
// sorted priority queue: chain of spq_cell plus count and result registers
// depends on spq_pkg and spq_cell
//
// Usage: drive func_i, item_value_i and item_priority_i with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// func_i = insert places the item behind all entries of equal or smaller
// priority number; func_i = remove takes the front entry. busy stays low, so
// a new transaction may be issued every cycle: throughput is one per cycle.
// The result is registered and appears in the cycle after the transaction,
// marked by done_o for exactly one cycle: out_value_o/out_priority_o carry the
// removed entry (zero on insert or failure), status_o flags removal from empty
// or insert into full, occupancy_o gives the entry count after the transaction.
// Every cell compares its priority with the incoming one in parallel and
// shifts toward its neighbor in the same cycle, for any fill level. The
// receiver cannot stall; each result is replaced by the next transaction's.
// Reset clears the entry count, done_o and status_o; cell contents are not
// cleared, cells past the count are never read.
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func_i,
  input  logic [VALUE_WIDTH-1:0]    item_value_i,
  input  logic [PRIORITY_WIDTH-1:0] item_priority_i,
  output logic                      done_o,
  output logic [VALUE_WIDTH-1:0]    out_value_o,
  output logic [PRIORITY_WIDTH-1:0] out_priority_o,
  output logic [1:0]                status_o,
  output logic [spq_pkg::OCC_W-1:0] occupancy_o
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      accept, full, empty;
  spq_ctrl_t                 ctrl;
  status_e                   status_d;
  logic                      done_q;
  status_e                   status_q;
  logic [VALUE_WIDTH-1:0]    out_value_q, out_value_d;
  logic [PRIORITY_WIDTH-1:0] out_prio_q, out_prio_d;

  logic [VALUE_WIDTH-1:0]    cell_value [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    cell_le;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty  = count_q == '0;

  always_comb begin
    ctrl.ins    = accept && (func_i == FUNC_INSERT) && !full;
    ctrl.rem    = accept && (func_i == FUNC_REMOVE) && !empty;
    count_d     = count_q;
    status_d    = ST_DONE;
    out_value_d = '0;
    out_prio_d  = '0;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d     = count_q - CNT_W'(1);
      out_value_d = cell_value[0];
      out_prio_d  = cell_prio[0];
    end
    if (accept && (func_i == FUNC_INSERT) && full) begin
      status_d = ST_FULL;
    end else if (accept && (func_i == FUNC_REMOVE) && empty) begin
      status_d = ST_EMPTY;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0]    prev_value, next_value;
    logic [PRIORITY_WIDTH-1:0] prev_prio, next_prio;
    logic                      prev_le;

    if (i == 0) begin : g_head
      // head cell: nothing in front, so an insert lands here when it is not le
      assign prev_value = item_value_i;
      assign prev_prio  = item_priority_i;
      assign prev_le    = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_prio  = cell_prio[i-1];
      assign prev_le    = cell_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_value = '0;
      assign next_prio  = '0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (count_q > CNT_W'(i)),
      .new_value_i  (item_value_i),
      .new_prio_i   (item_priority_i),
      .prev_value_i (prev_value),
      .prev_prio_i  (prev_prio),
      .prev_le_i    (prev_le),
      .next_value_i (next_value),
      .next_prio_i  (next_prio),
      .value_o      (cell_value[i]),
      .prio_o       (cell_prio[i]),
      .le_o         (cell_le[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      out_prio_q  <= out_prio_d;
    end
  end

  assign done_o         = done_q;
  assign out_value_o    = out_value_q;
  assign out_priority_o = out_prio_q;
  assign status_o       = status_q;
  assign occupancy_o    = OCC_W'(count_q);

endmodule

### rtl/spq_checker.sv
// port-level checker for sorted_priority_queue_top, bound to the top level
// depends on spq_pkg and sorted_priority_queue_top_macros.svh
`include "sorted_priority_queue_top_macros.svh"

module spq_checker #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int VALUE_WIDTH    = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [VALUE_WIDTH-1:0]    out_value_o,
  input logic [PRIORITY_WIDTH-1:0] out_priority_o,
  input logic [1:0]                status_o,
  input logic [spq_pkg::OCC_W-1:0] occupancy_o
);
  import spq_pkg::*;

  // every transaction gets its result on the next cycle
  `SPQ_ASSERT(a_latency, (start && !busy) |=> done_o, "missing result strobe")
  // a removal from empty can only report an empty queue
  `SPQ_ASSERT(a_empty_cnt,
              (done_o && status_o == ST_EMPTY) |-> occupancy_o == '0,
              "empty flag with entries held")
  // a dropped insert can only happen at full occupancy
  `SPQ_ASSERT(a_full_cnt,
              (done_o && status_o == ST_FULL) |-> occupancy_o == OCC_W'(QUEUE_DEPTH),
              "full flag below depth")
  // failed transactions return zero payload
  `SPQ_ASSERT(a_fail_zero,
              (done_o && status_o != ST_DONE) |-> (out_value_o == '0 && out_priority_o == '0),
              "payload on failed transaction")
  // reset silences the strobe
  `SPQ_ASSERT_ANY(a_rst_quiet, !rst_ni |-> !done_o, "result strobe during reset")

endmodule

bind sorted_priority_queue_top spq_checker #(
  .QUEUE_DEPTH    (QUEUE_DEPTH),
  .VALUE_WIDTH    (VALUE_WIDTH),
  .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_spq_checker (.*);

### tb/tb_sorted_priority_queue_top.sv
// testbench for sorted_priority_queue_top: directed and random insert/remove traffic
// with a built-in sorted-list predictor; depends on spq_pkg and the rtl top level
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int VW             = 32;
  localparam int PW             = 16;
  localparam int CNT_W          = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS   = 2000;
  localparam int BLOCK_LEN      = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [VW-1:0]    value;
    logic [PW-1:0]    prio;
    status_e          status;
    logic [CNT_W-1:0] count;
  } queue_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             func_i;
  logic [VW-1:0]    item_value_i;
  logic [PW-1:0]    item_priority_i;
  logic             done_o;
  logic [VW-1:0]    out_value_o;
  logic [PW-1:0]    out_priority_o;
  logic [1:0]       status_o;
  logic [CNT_W-1:0] occupancy_o;

  // predictor copy of the sorted list
  logic        [VW-1:0] held_values [DEPTH];
  logic signed [PW-1:0] held_prios  [DEPTH];
  int                   held_count;

  queue_result_t pending_results[$];
  queue_result_t head_result;
  int            err_cnt;
  int            idle_cycles;
  int            n_xfer;
  int            n_removed;
  int            n_empty;
  int            n_full;
  bit            quiet_block;

  sorted_priority_queue_top #(
    .QUEUE_DEPTH   (DEPTH),
    .VALUE_WIDTH   (VW),
    .PRIORITY_WIDTH(PW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic queue_result_t apply_queue_op(input logic f, input logic [VW-1:0] v,
                                                   input logic signed [PW-1:0] p);
    queue_result_t r;
    int pos;
    int i;
    r.value  = '0;
    r.prio   = '0;
    r.status = ST_DONE;
    if (f == FUNC_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind all entries of equal or smaller priority
        pos = 0;
        while (pos < held_count && held_prios[pos] <= p) pos++;
        for (i = held_count; i > pos; i--) begin
          held_values[i] = held_values[i-1];
          held_prios[i]  = held_prios[i-1];
        end
        held_values[pos] = v;
        held_prios[pos]  = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = held_values[0];
        r.prio  = held_prios[0];
        for (i = 1; i < held_count; i++) begin
          held_values[i-1] = held_values[i];
          held_prios[i-1]  = held_prios[i];
        end
        held_count--;
      end
    end
    r.count = CNT_W'(held_count);
    return r;
  endfunction

  // result check, prediction and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with no pending transaction");
          err_cnt++;
        end else begin
          head_result = pending_results.pop_front();
          if (out_value_o !== head_result.value) begin
            $error("out_value: expected %h, got %h", head_result.value, out_value_o);
            err_cnt++;
          end
          if (out_priority_o !== head_result.prio) begin
            $error("out_priority: expected %h, got %h", head_result.prio, out_priority_o);
            err_cnt++;
          end
          if (status_o !== head_result.status) begin
            $error("status: expected %0d, got %0d", head_result.status, status_o);
            err_cnt++;
          end
          if (occupancy_o !== head_result.count) begin
            $error("occupancy: expected %0d, got %0d", head_result.count, occupancy_o);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        head_result = apply_queue_op(func_i, item_value_i, item_priority_i);
        pending_results.push_back(head_result);
        n_xfer++;
        case (head_result.status)
          ST_EMPTY: n_empty++;
          ST_FULL:  n_full++;
          default:  if (func_i == FUNC_REMOVE) n_removed++;
        endcase
      end
      if (done_o || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int rand_gap();
    int r;
    if (quiet_block) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [PW-1:0] rand_prio();
    int r;
    r = $urandom_range(0, 99);
    // narrow range gives plenty of ties
    if (r < 50) return PW'($urandom_range(0, 6) - 3);
    if (r < 85) return PW'($urandom);
    case ($urandom_range(0, 3))
      0: return {1'b0, {(PW-1){1'b1}}};
      1: return {1'b1, {(PW-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_value();
    if ($urandom_range(0, 4) != 0) return VW'($urandom);
    case ($urandom_range(0, 3))
      0: return {1'b0, {(VW-1){1'b1}}};
      1: return {1'b1, {(VW-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // drive one transaction and hold it until taken
  task automatic send_item(input logic f, input logic [VW-1:0] v, input logic [PW-1:0] p,
                           input int gap);
    logic was_busy;
    start           <= 1'b1;
    func_i          <= f;
    item_value_i    <= v;
    item_priority_i <= p;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic test_empty_remove();
    send_item(FUNC_REMOVE, rand_value(), rand_prio(), rand_gap());
  endtask

  // extremes, ties kept in arrival order, then one insert too many
  task automatic test_fill_and_overflow();
    logic [VW-1:0] vals  [DEPTH];
    logic [PW-1:0] prios [DEPTH];
    int i;
    vals  = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h2, 32'h3,
              32'h4, 32'h5555_aaaa, 32'haaaa_5555, 32'h10, 32'h11, 32'h12, 32'h13,
              32'h0f0f_0f0f, 32'hf0f0_f0f0};
    prios = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0005, 16'h0005, 16'h0005,
              16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0005, 16'hfffb, 16'h0004,
              16'h0006, 16'h8000};
    for (i = 0; i < DEPTH; i++) send_item(FUNC_INSERT, vals[i], prios[i], rand_gap());
    send_item(FUNC_INSERT, 32'hdead_beef, 16'h8000, rand_gap());
  endtask

  task automatic test_front_removal();
    int i;
    for (i = 0; i < 4; i++) send_item(FUNC_REMOVE, rand_value(), rand_prio(), rand_gap());
    wait_drained();
  endtask

  // blocks with a changing insert bias so the list wanders between empty and full
  task automatic test_random_mix();
    int n;
    int bias;
    logic f;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 25;
          1: bias = 50;
          default: bias = 75;
        endcase
        quiet_block = ($urandom_range(0, 3) == 0);
        if (n != 0 && $urandom_range(0, 7) == 0) wait_drained();
      end
      f = ($urandom_range(0, 99) < bias) ? FUNC_INSERT : FUNC_REMOVE;
      send_item(f, rand_value(), rand_prio(), rand_gap());
    end
    quiet_block = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = FUNC_INSERT;
    item_value_i    = '0;
    item_priority_i = '0;
    held_count      = 0;
    err_cnt         = 0;
    idle_cycles     = 0;
    n_xfer          = 0;
    n_removed       = 0;
    n_empty         = 0;
    n_full          = 0;
    quiet_block     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_remove();
    test_fill_and_overflow();
    test_front_removal();
    test_random_mix();

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("covered %0d transactions: %0d removals with data, %0d from empty, %0d into full",
             n_xfer, n_removed, n_empty, n_full);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
rtl/spq_checker.sv
tb/tb_sorted_priority_queue_top.sv
